// ===== rtl/core/lcgr_pkg.sv =====
// Shared types, constants and helpers for the ranged LCG generator.
`default_nettype none
package lcgr_pkg;

    localparam logic [63:0] SEED_PATTERN = 64'hECC440A96968484A;
    localparam logic [31:0] LCG_MUL      = 32'd1103515245;
    localparam logic [63:0] LCG_ADD      = 64'd12345;
    localparam int          DIV_STEPS    = 64;
    localparam int          CNT_W        = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DIV,
        ST_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic div_step;
        logic fin;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic direct;
    } t_sts;

    function automatic logic [63:0] swap_bytes(input logic [63:0] x);
        logic [63:0] r;
        for (int b = 0; b < 8; b++) begin
            r[8*b +: 8] = x[8*(7-b) +: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lcg_byte_reversed_ranged_random.sv =====
// Reseed and non-stepping draws go from acceptance straight to the hand-off state;
// a stepping draw takes 3 multiply/add steps, 64 remainder steps, 1 add, 1 hand-off.
// The remainder loop yields one bit per cycle. A request is accepted only while idle, so a new
// request waits until the previous result is handed off. A waiting result holds the next finished
// request in place, and that request blocks the one after it.
// Reset: synchronous, active low; the seed returns to 0xECC440A96968484A, output empties.
`default_nettype none
module lcg_byte_reversed_ranged_random
    import lcgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_kind,
    input  wire logic [63:0] i_seed_value,
    input  wire logic [3:0]  i_seed_bytes,
    input  wire logic [63:0] i_range_lo,
    input  wire logic [63:0] i_range_hi,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [63:0] o_value,
    output logic             o_advanced
);

    t_cmd w_cmd;
    t_sts w_sts;

    lcgr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    lcgr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_kind       (i_kind),
        .i_seed_value (i_seed_value),
        .i_seed_bytes (i_seed_bytes),
        .i_range_lo   (i_range_lo),
        .i_range_hi   (i_range_hi),
        .o_value      (o_value),
        .o_advanced   (o_advanced)
    );

endmodule
`default_nettype wire

// ===== rtl/core/lcgr_ctrl.sv =====
// Sequencer for request handling, LCG step and bit-serial remainder.
`default_nettype none
module lcgr_ctrl
    import lcgr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_ovalid, n_ovalid;
    logic               w_accept;
    logic               w_out_free;

    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_ovalid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_sts.direct ? ST_DONE : ST_MUL_LO;
                end
            end
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_SUM;
            ST_SUM:    n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD:    n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = w_accept;
        o_cmd.mul_lo   = (r_state == ST_MUL_LO);
        o_cmd.mul_hi   = (r_state == ST_MUL_HI);
        o_cmd.sum      = (r_state == ST_SUM);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.fin      = (r_state == ST_ADD);
        o_cmd.load_out = (r_state == ST_DONE) && w_out_free;
        o_ready        = (r_state == ST_IDLE);
        o_valid        = r_ovalid;
    end

    always_comb begin
        n_cnt = (r_state == ST_DIV) ? r_cnt + CNT_W'(1) : '0;
        if (o_cmd.load_out) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lcgr_dp.sv =====
// Seed register, shared 32x32 multiplier, restoring remainder unit, result registers.
`default_nettype none
module lcgr_dp
    import lcgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        i_kind,
    input  wire logic [63:0] i_seed_value,
    input  wire logic [3:0]  i_seed_bytes,
    input  wire logic [63:0] i_range_lo,
    input  wire logic [63:0] i_range_hi,
    output logic      [63:0] o_value,
    output logic             o_advanced
);

    logic [63:0] r_seed, n_seed;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_lo;
    logic [63:0] r_span;
    logic [63:0] r_dvd;
    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic        r_adv;
    logic [63:0] r_value;
    logic        r_advanced;

    logic [63:0] w_reseed;
    logic [63:0] w_sum;
    logic [63:0] w_swapped;
    logic [31:0] w_mul_op;
    logic [64:0] w_trial;
    logic [64:0] w_diff;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            if ((i_seed_bytes > 4'd8) || (4'(b) < i_seed_bytes)) begin
                w_reseed[8*b +: 8] = i_seed_value[8*b +: 8];
            end else begin
                w_reseed[8*b +: 8] = SEED_PATTERN[8*b +: 8];
            end
        end
    end

    assign o_sts.direct = !i_kind || (i_range_hi <= i_range_lo)
                        || ((i_range_lo == '0) && (i_range_hi == '1));

    assign w_mul_op  = i_cmd.mul_hi ? r_seed[63:32] : r_seed[31:0];
    assign w_sum     = r_acc + {r_prod[31:0], 32'h0};
    assign w_swapped = swap_bytes(w_sum);
    assign w_trial   = {r_rem, r_dvd[63]};
    assign w_diff    = w_trial - {1'b0, r_span};

    always_comb begin
        n_seed = r_seed;
        if (i_cmd.accept && !i_kind) begin
            n_seed = w_reseed;
        end else if (i_cmd.sum) begin
            n_seed = w_swapped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_PATTERN;
        end else begin
            r_seed <= n_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo || i_cmd.mul_hi) begin
            r_prod <= w_mul_op * LCG_MUL;
        end
        if (i_cmd.mul_hi) begin
            r_acc <= r_prod + LCG_ADD;
        end
        if (i_cmd.accept) begin
            r_lo   <= i_range_lo;
            r_span <= i_range_hi - i_range_lo + 64'd1;
            r_res  <= i_kind ? i_range_lo : w_reseed;
            r_adv  <= 1'b0;
        end
        if (i_cmd.sum) begin
            r_dvd <= w_swapped;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_rem <= w_diff[64] ? w_trial[63:0] : w_diff[63:0];
        end
        if (i_cmd.fin) begin
            r_res <= r_lo + r_rem;
            r_adv <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_value    <= r_res;
            r_advanced <= r_adv;
        end
    end

    assign o_value    = r_value;
    assign o_advanced = r_advanced;

endmodule
`default_nettype wire

// ===== rtl/core/lcgr_chk.sv =====
// Port-level checker for the ranged LCG generator, bound to the top level.
`default_nettype none
module lcgr_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        i_kind,
    input wire logic [63:0] i_range_lo,
    input wire logic [63:0] i_range_hi,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [63:0] o_value,
    input wire logic        o_advanced
);

    logic w_step_draw;

    assign w_step_draw = i_valid && o_ready && i_kind && (i_range_hi > i_range_lo)
                       && !((i_range_lo == 64'd0) && (i_range_hi == '1));

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output not empty after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while previous still in work");

    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_draw |-> ##66 !o_ready)
        else $error("stepping draw finished too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_advanced))
        else $error("stalled result changed");

endmodule

bind lcg_byte_reversed_ranged_random lcgr_chk u_chk (.*);
`default_nettype wire
